// ----- sv/assert_macros.svh -----
// assertion macros used by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rstn, prop)

`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- sv/rpr_pkg.sv -----
// types, constants and helpers of the preamble rnti table
`timescale 1ns / 1ps

package rpr_pkg;

    localparam int PREAMBLE_SLOTS = 64;
    localparam int UE_COUNT       = 1024;

    localparam int PRE_W  = 6;
    localparam int UE_W   = 10;
    localparam int RNTI_W = 16;
    localparam int TA_W   = 12;
    localparam int CNT_W  = 7;
    localparam int HELD_W = 7;
    localparam int STAT_W = 3;
    localparam int FUNC_W = 2;

    localparam int SLOT_AW = (PREAMBLE_SLOTS > 1) ? $clog2(PREAMBLE_SLOTS) : 1;
    localparam int UE_AW   = (UE_COUNT > 1) ? $clog2(UE_COUNT) : 1;

    localparam logic [CNT_W-1:0]  SLOTS_LIMIT  = CNT_W'(PREAMBLE_SLOTS);
    localparam logic [HELD_W-1:0] NO_PREAMBLE  = HELD_W'(64);
    localparam logic [RNTI_W-1:0] FREE_RNTI    = '0;
    localparam logic [CNT_W-1:0]  CNT_RESET    = CNT_W'(64);
    localparam logic [UE_AW-1:0]  UE_LAST      = UE_AW'(UE_COUNT - 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_DETECT  = 2'd0,
        FUNC_RESERVE = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_CFRA_HIT  = 3'd0,
        STAT_CBRA      = 3'd1,
        STAT_DROPPED   = 3'd2,
        STAT_RESERVED  = 3'd3,
        STAT_REFUSED   = 3'd4,
        STAT_RELEASED  = 3'd5,
        STAT_NONE_HELD = 3'd6
    } status_t;

    typedef enum logic {
        CFG_CB_COUNT    = 1'b0,
        CFG_TOTAL_COUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } state_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_AW-1:0] slot;
    } cfra_t;

    // contention-free when cb <= p < total and the slot falls inside the table
    function automatic cfra_t cfra_check(input logic [PRE_W-1:0] p,
                                         input logic [CNT_W-1:0] cb,
                                         input logic [CNT_W-1:0] total);
        cfra_t            r;
        logic [CNT_W-1:0] pw;
        logic [CNT_W-1:0] diff;
        pw    = CNT_W'(p);
        diff  = pw - cb;
        r.hit  = (pw >= cb) && (pw < total) && (diff < SLOTS_LIMIT);
        r.slot = SLOT_AW'(diff);
        return r;
    endfunction

endpackage

// ----- sv/rach_preamble_rnti_table.sv -----
// contention-free preamble reservation table with per-ue held preamble
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Keeps the C-RNTI reserved on each contention-free preamble slot and the
// preamble each UE holds. Every input transfer (detect, reserve, release)
// yields exactly one result transfer. When an item is accepted both tables
// are read into registers; in the execute state, once the result register
// is free to load, the result is formed and the tables are written back.
// A new item is taken only after the previous one leaves the execute state.
// The per-UE table's UE_COUNT entries are cleared after reset while no
// item is accepted; configuration writes are taken at any time but must only
// change while the block is idle.
module rach_preamble_rnti_table (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [rpr_pkg::CNT_W-1:0]     cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rpr_pkg::FUNC_W-1:0]    s_func,
    input  logic [rpr_pkg::PRE_W-1:0]     s_preamble_index,
    input  logic [rpr_pkg::UE_W-1:0]      s_ue_number,
    input  logic [rpr_pkg::RNTI_W-1:0]    s_cell_rnti,
    input  logic [rpr_pkg::TA_W-1:0]      s_timing_advance,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rpr_pkg::STAT_W-1:0]    m_status,
    output logic [rpr_pkg::RNTI_W-1:0]    m_rnti_out,
    output logic [rpr_pkg::PRE_W-1:0]     m_preamble_out,
    output logic [rpr_pkg::TA_W-1:0]      m_timing_advance_out
);

    // configuration
    logic [rpr_pkg::CNT_W-1:0] cb_count_reg;
    logic [rpr_pkg::CNT_W-1:0] total_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cb_count_reg    <= rpr_pkg::CNT_RESET;
            total_count_reg <= rpr_pkg::CNT_RESET;
        end else if (cfg_we) begin
            case (rpr_pkg::cfg_idx_t'(cfg_addr))
                rpr_pkg::CFG_CB_COUNT:    cb_count_reg    <= cfg_wdata;
                rpr_pkg::CFG_TOTAL_COUNT: total_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // state machine
    rpr_pkg::state_t state_reg;
    rpr_pkg::state_t state_next;
    logic [rpr_pkg::UE_AW-1:0] clr_cnt_reg;
    logic [rpr_pkg::UE_AW-1:0] clr_cnt_next;

    logic accept;
    logic out_free;
    logic exec_done;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            rpr_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + rpr_pkg::UE_AW'(1);
                if (clr_cnt_reg == rpr_pkg::UE_LAST) begin
                    state_next = rpr_pkg::ST_IDLE;
                end
            end
            rpr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rpr_pkg::ST_EXEC;
                end
            end
            rpr_pkg::ST_EXEC: begin
                if (out_free) begin
                    state_next = rpr_pkg::ST_IDLE;
                end
            end
            default: state_next = rpr_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        exec_done = 1'b0;
        case (state_reg)
            rpr_pkg::ST_IDLE: s_ready   = 1'b1;
            rpr_pkg::ST_EXEC: exec_done = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rpr_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // item registers, loaded on the accepting transfer
    rpr_pkg::cfra_t               in_cfra;
    logic [rpr_pkg::FUNC_W-1:0]   func_reg;
    logic [rpr_pkg::PRE_W-1:0]    pre_reg;
    logic [rpr_pkg::RNTI_W-1:0]   rnti_reg;
    logic [rpr_pkg::TA_W-1:0]     ta_reg;
    logic                         ue_ok_reg;
    logic [rpr_pkg::UE_AW-1:0]    ue_addr_reg;
    rpr_pkg::cfra_t               cfra_reg;

    assign in_cfra = rpr_pkg::cfra_check(s_preamble_index, cb_count_reg, total_count_reg);

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg    <= s_func;
            pre_reg     <= s_preamble_index;
            rnti_reg    <= s_cell_rnti;
            ta_reg      <= s_timing_advance;
            ue_ok_reg   <= (32'(s_ue_number) < 32'(rpr_pkg::UE_COUNT));
            ue_addr_reg <= rpr_pkg::UE_AW'(s_ue_number);
            cfra_reg    <= in_cfra;
        end
    end

    // slot table: memory plus one valid bit per slot, invalid reads as free
    logic [rpr_pkg::RNTI_W-1:0] slot_mem [rpr_pkg::PREAMBLE_SLOTS];
    logic [rpr_pkg::PREAMBLE_SLOTS-1:0] slot_vld_reg;
    logic [rpr_pkg::RNTI_W-1:0] slot_rd_reg;
    logic                       slot_rd_vld_reg;
    logic [rpr_pkg::RNTI_W-1:0] slot_cur;

    // per-ue table
    logic [rpr_pkg::HELD_W-1:0] ue_mem [rpr_pkg::UE_COUNT];
    logic [rpr_pkg::HELD_W-1:0] ue_rd_reg;
    logic                       ue_we;
    logic [rpr_pkg::UE_AW-1:0]  ue_waddr;
    logic [rpr_pkg::HELD_W-1:0] ue_wdata;

    // execute
    rpr_pkg::cfra_t              held_cfra;
    logic                        held_some;
    logic                        reserve_ok;
    logic                        release_ok;
    rpr_pkg::status_t            status_c;
    logic [rpr_pkg::RNTI_W-1:0]  rnti_c;
    logic [rpr_pkg::PRE_W-1:0]   pre_c;
    logic [rpr_pkg::TA_W-1:0]    ta_c;

    assign slot_cur   = slot_rd_vld_reg ? slot_rd_reg : rpr_pkg::FREE_RNTI;
    assign held_some  = (ue_rd_reg != rpr_pkg::NO_PREAMBLE);
    assign held_cfra  = rpr_pkg::cfra_check(ue_rd_reg[rpr_pkg::PRE_W-1:0],
                                            cb_count_reg, total_count_reg);
    assign reserve_ok = (rpr_pkg::func_t'(func_reg) == rpr_pkg::FUNC_RESERVE) && ue_ok_reg
                        && (rnti_reg != rpr_pkg::FREE_RNTI) && cfra_reg.hit && !held_some
                        && (slot_cur == rpr_pkg::FREE_RNTI);
    assign release_ok = (rpr_pkg::func_t'(func_reg) == rpr_pkg::FUNC_RELEASE) && ue_ok_reg
                        && held_some;

    always_comb begin
        status_c = rpr_pkg::STAT_REFUSED;
        rnti_c   = '0;
        pre_c    = pre_reg;
        ta_c     = '0;
        case (rpr_pkg::func_t'(func_reg))
            rpr_pkg::FUNC_DETECT: begin
                ta_c = ta_reg;
                if (!cfra_reg.hit) begin
                    status_c = rpr_pkg::STAT_CBRA;
                end else if (slot_cur == rpr_pkg::FREE_RNTI) begin
                    status_c = rpr_pkg::STAT_DROPPED;
                end else begin
                    status_c = rpr_pkg::STAT_CFRA_HIT;
                    rnti_c   = slot_cur;
                end
            end
            rpr_pkg::FUNC_RESERVE: begin
                status_c = reserve_ok ? rpr_pkg::STAT_RESERVED : rpr_pkg::STAT_REFUSED;
            end
            rpr_pkg::FUNC_RELEASE: begin
                if (release_ok) begin
                    status_c = rpr_pkg::STAT_RELEASED;
                    pre_c    = ue_rd_reg[rpr_pkg::PRE_W-1:0];
                end else begin
                    status_c = rpr_pkg::STAT_NONE_HELD;
                    pre_c    = '0;
                end
            end
            default: ;
        endcase
    end

    // ue table write port shared by the clearing pass and the write-back
    always_comb begin
        ue_we    = 1'b0;
        ue_waddr = ue_addr_reg;
        ue_wdata = rpr_pkg::NO_PREAMBLE;
        if (state_reg == rpr_pkg::ST_CLEAR) begin
            ue_we    = 1'b1;
            ue_waddr = clr_cnt_reg;
        end else if (exec_done && reserve_ok) begin
            ue_we    = 1'b1;
            ue_wdata = rpr_pkg::HELD_W'(pre_reg);
        end else if (exec_done && release_ok) begin
            ue_we    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ue_we) begin
            ue_mem[ue_waddr] <= ue_wdata;
        end
        if (accept) begin
            ue_rd_reg <= ue_mem[rpr_pkg::UE_AW'(s_ue_number)];
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_done && reserve_ok) begin
            slot_mem[cfra_reg.slot] <= rnti_reg;
        end
        if (accept) begin
            slot_rd_reg     <= slot_mem[in_cfra.slot];
            slot_rd_vld_reg <= slot_vld_reg[in_cfra.slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg <= '0;
        end else if (exec_done && reserve_ok) begin
            slot_vld_reg[cfra_reg.slot] <= 1'b1;
        end else if (exec_done && release_ok && held_cfra.hit) begin
            // release frees the slot only while the held preamble is still cfra
            slot_vld_reg[held_cfra.slot] <= 1'b0;
        end
    end

    // result register
    logic                         m_valid_reg;
    logic [rpr_pkg::STAT_W-1:0]   status_reg;
    logic [rpr_pkg::RNTI_W-1:0]   rnti_out_reg;
    logic [rpr_pkg::PRE_W-1:0]    pre_out_reg;
    logic [rpr_pkg::TA_W-1:0]     ta_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_done) begin
            status_reg   <= status_c;
            rnti_out_reg <= rnti_c;
            pre_out_reg  <= pre_c;
            ta_out_reg   <= ta_c;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_status             = status_reg;
    assign m_rnti_out           = rnti_out_reg;
    assign m_preamble_out       = pre_out_reg;
    assign m_timing_advance_out = ta_out_reg;

    `ASSERT_PROP(a_no_accept_in_clear, aclk, aresetn, (state_reg == rpr_pkg::ST_CLEAR) |-> !s_ready)
    `ASSERT_NEXT(a_accept_to_exec, aclk, aresetn, accept, state_reg == rpr_pkg::ST_EXEC)
    `ASSERT_PROP(a_result_from_exec, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == rpr_pkg::ST_EXEC))
    `ASSERT_NEXT(a_reserve_marks_slot, aclk, aresetn, exec_done && reserve_ok, slot_vld_reg[$past(cfra_reg.slot)])

endmodule
